### hw/rtl/hsfg_pkg.sv
// Shared widths and constant tables for the brick element gradient block.
// No dependencies; imported by hex_shape_function_gradient.
package hsfg_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int SUM_W    = COORD_W + 3;          // Jacobian sum of eight coordinates
    localparam int ADJ_W    = 2 * SUM_W + 1;        // cofactor entry
    localparam int ACC_W    = 3 * SUM_W + 3;        // determinant accumulator
    localparam int MAG_W    = ACC_W - 2;            // determinant magnitude
    localparam int NMAG_W   = ADJ_W + 1;            // magnitude of a cofactor row sum
    localparam int NUM_W    = ACC_W - 1;            // dividend and divisor width
    localparam int REM_W    = NUM_W + 1;
    localparam int QSH      = 2 * FRAC_W + 1;       // dividend scale
    localparam int THR_W    = 63;
    localparam int THR_SH   = 9;                    // det(S) = 512 * det(J)
    localparam int NTERMS   = 21;
    localparam int MUL_STEPS = SUM_W;

    // Bit k set where the centroid derivative of node k along that parametric axis is negative.
    localparam logic [7:0] DS_NEG [3] = '{8'b0011_0011, 8'b0000_1111, 8'b1001_1001};

    // Product terms: 18 for the cofactors (two per entry), then three for the determinant.
    localparam logic [3:0] TERM_A [NTERMS] = '{
        4'd4, 4'd5, 4'd7, 4'd8, 4'd1, 4'd2, 4'd5, 4'd3, 4'd8, 4'd6,
        4'd2, 4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd0, 4'd1, 4'd0, 4'd3, 4'd6};
    localparam logic [3:0] TERM_B [NTERMS] = '{
        4'd8, 4'd7, 4'd2, 4'd1, 4'd5, 4'd4, 4'd6, 4'd8, 4'd0, 4'd2,
        4'd3, 4'd5, 4'd7, 4'd6, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd1, 4'd2};

endpackage

### hw/rtl/hex_shape_function_gradient.sv
// Shape function gradients of an 8-node brick element at its centroid.
// Depends on hsfg_pkg for widths and the constant term tables.
//
// Usage:
//   s_ channel: one node per transfer (coord_x/y/z, signed Q16.16), nodes 0..7 in order.
//   m_ channel: after the eighth node, eight results, one per node, node_number 0..7,
//   last_node set on node 7. cfg_ channel writes det_threshold (reset value 1);
//   write it only while the block is idle.
//   Nodes 0..6 are taken one per cycle. The eighth node starts the element solve:
//   21 products on one shift-add multiplier, then per node and axis a three-term
//   cofactor sum and a 32-step restoring divider. Degenerate elements skip the
//   division and give one result per cycle of m_ready.
//   s_ready is low from the eighth node until the last result transfers.
//   A stalled receiver simply holds the current result; nothing is lost.
//   Reset clears the Jacobian sums and node count and aborts any element in flight.
module hex_shape_function_gradient
    import hsfg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_node_number,
    output logic signed [COORD_W-1:0] m_deriv_x,
    output logic signed [COORD_W-1:0] m_deriv_y,
    output logic signed [COORD_W-1:0] m_deriv_z,
    output logic                      m_degenerate,
    output logic                      m_saturated,
    output logic                      m_last_node,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [THR_W-1:0]          cfg_data
);

    typedef enum logic [3:0] {
        IDLE, LD_A, LD_B, MUL, THR, NSUM, DPREP, DIV, STORE, EMIT
    } state_t;

    state_t                    state_reg;
    logic signed [SUM_W-1:0]   s_reg [9];
    logic signed [ADJ_W-1:0]   adj_reg [9];
    logic signed [ACC_W-1:0]   acc_reg, opa_reg, det_reg;
    logic [SUM_W-1:0]          opb_reg;
    logic [5:0]                cnt_reg;
    logic [4:0]                term_reg;
    logic [2:0]                nodes_reg, k_reg;
    logic [1:0]                axis_reg, i_reg;
    logic [3:0]                aptr_reg;
    logic [THR_W-1:0]          thr_reg;
    logic                      degen_reg, neg_reg, sat_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [COORD_W-1:0]        low_reg, q_reg;
    logic [NUM_W-1:0]          den_reg;
    logic [COORD_W-1:0]        dv_reg [3];

    logic signed [ACC_W-1:0]   acc_next, addend;
    logic                      sub;
    logic [3:0]                s_idx, a_idx;
    logic signed [SUM_W-1:0]   s_rd;
    logic signed [ADJ_W-1:0]   adj_rd;
    logic [MAG_W-1:0]          dmag;
    logic [ACC_W-1:0]          acc_abs;
    logic [NUM_W-1:0]          num;
    logic [REM_W-1:0]          rem2;
    logic                      fits;
    logic [COORD_W-1:0]        lim, mag;
    logic signed [COORD_W-1:0] cin [3];

    assign cin[0] = s_coord_x;
    assign cin[1] = s_coord_y;
    assign cin[2] = s_coord_z;

    assign s_ready   = (state_reg == IDLE);
    assign m_valid   = (state_reg == EMIT);
    assign cfg_ready = 1'b1;
    assign m_node_number = k_reg;
    assign m_deriv_x = dv_reg[0];
    assign m_deriv_y = dv_reg[1];
    assign m_deriv_z = dv_reg[2];
    assign m_degenerate = degen_reg;
    assign m_saturated  = sat_reg;
    assign m_last_node  = (k_reg == 3'd7);

    assign s_idx  = (state_reg == LD_A) ? TERM_A[term_reg] : TERM_B[term_reg];
    assign a_idx  = (state_reg == LD_A) ? TERM_A[term_reg] : aptr_reg;
    assign s_rd   = s_reg[s_idx];
    assign adj_rd = adj_reg[a_idx];

    // The shared adder: multiply steps, cofactor row sums.
    always_comb begin
        sub    = 1'b0;
        addend = '0;
        if (state_reg == MUL) begin
            sub = (term_reg[0] && term_reg < 5'd18) ^ (cnt_reg == 6'(MUL_STEPS - 1));
            addend = opb_reg[0] ? opa_reg : '0;
        end else if (state_reg == NSUM) begin
            sub = DS_NEG[i_reg][k_reg];
            addend = {{(ACC_W-ADJ_W){adj_rd[ADJ_W-1]}}, adj_rd};
        end
        acc_next = ((state_reg == NSUM && i_reg == 2'd0) ? '0 : acc_reg)
                   + (sub ? -addend : addend);
    end

    always_comb begin
        logic [ACC_W-1:0] dabs;
        dabs    = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : ACC_W'(det_reg);
        dmag    = dabs[MAG_W-1:0];
        acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        num     = {acc_abs[NMAG_W-1:0], {QSH{1'b0}}} + NUM_W'(dmag);
        fits    = NUM_W'(num[NUM_W-1:COORD_W]) < {dmag, 1'b0};
        rem2    = {rem_reg[REM_W-2:0], low_reg[COORD_W-1]};
        lim     = neg_reg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        mag     = (q_reg > lim) ? lim : q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            nodes_reg <= '0;
            thr_reg   <= THR_W'(1);
            for (int j = 0; j < 9; j++) s_reg[j] <= '0;
        end else begin
            if (cfg_valid) thr_reg <= cfg_data;
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        for (int r = 0; r < 3; r++)
                            for (int c = 0; c < 3; c++)
                                s_reg[r*3+c] <= DS_NEG[r][nodes_reg]
                                    ? s_reg[r*3+c] - SUM_W'(cin[c])
                                    : s_reg[r*3+c] + SUM_W'(cin[c]);
                        nodes_reg <= nodes_reg + 3'd1;
                        if (nodes_reg == 3'd7) begin
                            term_reg  <= '0;
                            state_reg <= LD_A;
                        end
                    end
                end
                LD_A: begin
                    opa_reg <= (term_reg < 5'd18)
                        ? {{(ACC_W-SUM_W){s_rd[SUM_W-1]}}, s_rd}
                        : {{(ACC_W-ADJ_W){adj_rd[ADJ_W-1]}}, adj_rd};
                    // Cofactor pairs start on even terms; the determinant sums its three terms.
                    if ((!term_reg[0] && term_reg < 5'd18) || term_reg == 5'd18)
                        acc_reg <= '0;
                    state_reg <= LD_B;
                end
                LD_B: begin
                    opb_reg   <= s_rd;
                    cnt_reg   <= '0;
                    state_reg <= MUL;
                end
                MUL: begin
                    acc_reg <= acc_next;
                    opa_reg <= opa_reg <<< 1;
                    opb_reg <= opb_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(MUL_STEPS - 1)) begin
                        if (term_reg[0] && term_reg < 5'd18)
                            adj_reg[term_reg[4:1]] <= acc_next[ADJ_W-1:0];
                        term_reg <= term_reg + 5'd1;
                        if (term_reg == 5'(NTERMS - 1)) begin
                            det_reg   <= acc_next;
                            state_reg <= THR;
                        end else begin
                            state_reg <= LD_A;
                        end
                    end
                end
                THR: begin
                    // A zero determinant is always degenerate, even at threshold zero.
                    degen_reg <= (dmag == '0) ||
                                 (dmag < MAG_W'({thr_reg, {THR_SH{1'b0}}}));
                    k_reg    <= '0;
                    axis_reg <= '0;
                    i_reg    <= '0;
                    aptr_reg <= '0;
                    sat_reg  <= 1'b0;
                    if ((dmag == '0) || (dmag < MAG_W'({thr_reg, {THR_SH{1'b0}}}))) begin
                        for (int j = 0; j < 3; j++) dv_reg[j] <= '0;
                        state_reg <= EMIT;
                    end else begin
                        state_reg <= NSUM;
                    end
                end
                NSUM: begin
                    acc_reg  <= acc_next;
                    aptr_reg <= aptr_reg + 4'd1;
                    i_reg    <= i_reg + 2'd1;
                    if (i_reg == 2'd2) begin
                        i_reg     <= '0;
                        state_reg <= DPREP;
                    end
                end
                DPREP: begin
                    neg_reg <= acc_reg[ACC_W-1] ^ det_reg[ACC_W-1];
                    den_reg <= {dmag, 1'b0};
                    rem_reg <= REM_W'(num[NUM_W-1:COORD_W]);
                    low_reg <= num[COORD_W-1:0];
                    cnt_reg <= '0;
                    q_reg   <= '0;
                    if (fits) begin
                        state_reg <= DIV;
                    end else begin
                        // Quotient of 2^32 or more: clip at once.
                        q_reg     <= '1;
                        state_reg <= STORE;
                    end
                end
                DIV: begin
                    if (rem2 >= {1'b0, den_reg}) begin
                        rem_reg <= rem2 - {1'b0, den_reg};
                        q_reg   <= {q_reg[COORD_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem2;
                        q_reg   <= {q_reg[COORD_W-2:0], 1'b0};
                    end
                    low_reg <= low_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(COORD_W - 1)) state_reg <= STORE;
                end
                STORE: begin
                    dv_reg[axis_reg] <= neg_reg ? -mag : mag;
                    if (q_reg > lim) sat_reg <= 1'b1;
                    if (axis_reg == 2'd2) begin
                        axis_reg  <= '0;
                        state_reg <= EMIT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= NSUM;
                    end
                end
                EMIT: begin
                    if (m_ready) begin
                        k_reg    <= k_reg + 3'd1;
                        aptr_reg <= '0;
                        sat_reg  <= 1'b0;
                        if (k_reg == 3'd7) begin
                            for (int j = 0; j < 9; j++) s_reg[j] <= '0;
                            nodes_reg <= '0;
                            state_reg <= IDLE;
                        end else if (!degen_reg) begin
                            state_reg <= NSUM;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while results pending");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_node |=> s_ready)
        else $error("block not idle after last result");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_deriv_x == '0 && m_deriv_y == '0 &&
                                    m_deriv_z == '0 && !m_saturated)
        else $error("degenerate result carries data");

    a_node_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_node |=> m_node_number == $past(m_node_number) + 3'd1)
        else $error("node number skipped");

endmodule
